// ===== rtl/rnus_pkg.sv =====
// rnus_pkg: types and constants shared by the radio node upload sequencer
// phase codes, item structs, configuration bundle; no dependencies
package rnus_pkg;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_LISTEN = 4'd1,
        PH_IDLE   = 4'd2,
        PH_SLEEP  = 4'd3,
        PH_PING   = 4'd4,
        PH_WPONG  = 4'd5,
        PH_PREP   = 4'd6,
        PH_WREADY = 4'd7,
        PH_READ   = 4'd8,
        PH_SEND   = 4'd9,
        PH_WACK   = 4'd10
    } phase_t;

    localparam logic       OP_TICK   = 1'b0;
    localparam logic       OP_PACKET = 1'b1;

    localparam logic [2:0] PK_PONG   = 3'd1;
    localparam logic [2:0] PK_ACK    = 3'd4;

    localparam logic [1:0] CS_READY  = 2'd1;
    localparam logic [1:0] CS_END    = 2'd2;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_PING = 2'd1;
    localparam logic [1:0] SEND_PREP = 2'd2;
    localparam logic [1:0] SEND_DATA = 2'd3;

    localparam logic [1:0] MODE_KEEP = 2'd0;
    localparam logic [1:0] MODE_IDLE = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_RETRY  = 2'd1;
    localparam logic [1:0] EV_FAIL   = 2'd2;
    localparam logic [1:0] EV_DONE   = 2'd3;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DEVICE  = 2'd0;
    localparam logic [1:0] REG_LISTEN  = 2'd1;
    localparam logic [1:0] REG_RECEIVE = 2'd2;
    localparam logic [1:0] REG_RETRIES = 2'd3;

    localparam logic [31:0] DEVICE_RST  = 32'd0;
    localparam logic [23:0] LISTEN_RST  = 24'd5000;
    localparam logic [23:0] RECEIVE_RST = 24'd1000;
    localparam logic [7:0]  RETRIES_RST = 8'd3;

    localparam logic [7:0]  CHUNK_MAX   = 8'd255;
    localparam int          ELAPSED_W   = 25;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef struct packed {
        logic [31:0] own_device_id;
        logic [23:0] listen_window_ms;
        logic [23:0] receive_window_ms;
        logic [7:0]  max_retries;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  packet_kind;
        logic [31:0] packet_device;
        logic        radio_transmitting;
        logic [1:0]  chunk_status;
        logic [7:0]  chunk_length;
        logic [23:0] drawn_wait;
    } in_item_t;

    typedef struct packed {
        logic [3:0] node_state;
        logic [1:0] send_kind;
        logic [7:0] send_sequence;
        logic [7:0] send_length;
        logic [1:0] radio_mode;
        logic       read_request;
        logic [1:0] event_res;
    } res_item_t;

endpackage

// ===== rtl/rnus_cfg.sv =====
// rnus_cfg: apb register file holding the four configuration registers
// depends on rnus_pkg for the register indexes, reset values and cfg_t
module rnus_cfg
    import rnus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_device_id     <= DEVICE_RST;
            cfg_reg.listen_window_ms  <= LISTEN_RST;
            cfg_reg.receive_window_ms <= RECEIVE_RST;
            cfg_reg.max_retries       <= RETRIES_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEVICE:  cfg_reg.own_device_id     <= pwdata;
                REG_LISTEN:  cfg_reg.listen_window_ms  <= pwdata[23:0];
                REG_RECEIVE: cfg_reg.receive_window_ms <= pwdata[23:0];
                REG_RETRIES: cfg_reg.max_retries       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEVICE:  prdata = cfg_reg.own_device_id;
            REG_LISTEN:  prdata = {8'd0, cfg_reg.listen_window_ms};
            REG_RECEIVE: prdata = {8'd0, cfg_reg.receive_window_ms};
            REG_RETRIES: prdata = {24'd0, cfg_reg.max_retries};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/rnus_core.sv =====
// rnus_core: node state registers and the combinational phase update
// depends on rnus_pkg for phase_t, item structs and field codes
module rnus_core
    import rnus_pkg::*;
#(
    parameter int SEQ_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      step,
    input  in_item_t  item,
    output res_item_t res
);

    phase_t                phase_reg, phase_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [23:0]           wait_reg, wait_next;
    logic [7:0]            retry_reg, retry_next;
    logic [SEQ_BITS-1:0]   seq_reg, seq_next;
    logic [7:0]            held_reg, held_next;

    logic [ELAPSED_W-1:0]  elapsed_inc;
    logic                  listen_passed;
    logic                  receive_passed;
    logic                  timer_done;
    logic                  traffic;
    logic [SEQ_BITS+7:0]   seq_ext;
    logic [7:0]            seq_low;
    logic [7:0]            clen_clip;

    assign elapsed_inc    = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign listen_passed  = elapsed_inc > {1'b0, cfg.listen_window_ms};
    assign receive_passed = elapsed_inc > {1'b0, cfg.receive_window_ms};
    assign timer_done     = (wait_reg != 24'd0) && (elapsed_inc > {1'b0, wait_reg});
    assign traffic        = (item.packet_kind != PK_ACK)
                            && (item.packet_device != cfg.own_device_id);
    assign seq_ext        = {8'd0, seq_reg};
    assign seq_low        = seq_ext[7:0];
    assign clen_clip      = (item.chunk_length > CHUNK_MAX) ? CHUNK_MAX : item.chunk_length;

    always_comb
    begin
        phase_next        = phase_reg;
        elapsed_next      = elapsed_reg;
        wait_next         = wait_reg;
        retry_next        = retry_reg;
        seq_next          = seq_reg;
        held_next         = held_reg;
        res.send_kind     = SEND_NONE;
        res.send_sequence = 8'd0;
        res.send_length   = 8'd0;
        res.radio_mode    = MODE_KEEP;
        res.read_request  = 1'b0;
        res.event_res     = EV_NONE;

        if (item.opcode == OP_TICK)
        begin
            elapsed_next = elapsed_inc;
            unique case (phase_reg) inside
                PH_START:
                begin
                    retry_next   = 8'd0;
                    phase_next   = PH_LISTEN;
                    elapsed_next = '0;
                    wait_next    = 24'd0;
                end
                PH_IDLE, PH_SLEEP:
                begin
                    res.radio_mode = MODE_IDLE;
                    if (timer_done)
                    begin
                        phase_next   = PH_LISTEN;
                        elapsed_next = '0;
                        wait_next    = 24'd0;
                    end
                end
                PH_LISTEN:
                begin
                    retry_next     = 8'd0;
                    res.radio_mode = MODE_RX;
                    if (listen_passed)
                    begin
                        phase_next   = PH_PING;
                        elapsed_next = '0;
                        wait_next    = 24'd0;
                    end
                end
                PH_PING:
                begin
                    res.send_kind     = SEND_PING;
                    res.send_sequence = seq_low;
                    phase_next        = PH_WPONG;
                    elapsed_next      = '0;
                    wait_next         = 24'd0;
                end
                PH_PREP:
                begin
                    res.send_kind     = SEND_PREP;
                    res.send_sequence = seq_low;
                    phase_next        = PH_WREADY;
                    elapsed_next      = '0;
                    wait_next         = 24'd0;
                end
                PH_SEND:
                begin
                    res.send_kind     = SEND_DATA;
                    res.send_sequence = seq_low;
                    res.send_length   = held_reg;
                    phase_next        = PH_WACK;
                    elapsed_next      = '0;
                    wait_next         = 24'd0;
                end
                PH_WPONG, PH_WREADY, PH_WACK:
                begin
                    // waits hold off while the radio is still transmitting
                    if (!item.radio_transmitting)
                    begin
                        res.radio_mode = MODE_RX;
                        if (receive_passed)
                        begin
                            elapsed_next = '0;
                            wait_next    = 24'd0;
                            if (phase_reg != PH_WPONG && retry_reg < cfg.max_retries)
                            begin
                                retry_next    = retry_reg + 1'b1;
                                res.event_res = EV_RETRY;
                                phase_next    = (phase_reg == PH_WREADY) ? PH_PREP : PH_SEND;
                            end
                            else
                            begin
                                res.event_res = EV_FAIL;
                                phase_next    = PH_LISTEN;
                            end
                        end
                    end
                end
                PH_READ:
                begin
                    res.read_request = 1'b1;
                    if (item.chunk_status == CS_END)
                    begin
                        res.event_res = EV_DONE;
                        phase_next    = PH_IDLE;
                        elapsed_next  = '0;
                        wait_next     = item.drawn_wait;
                    end
                    else if (item.chunk_status == CS_READY && item.chunk_length != 8'd0)
                    begin
                        held_next    = clen_clip;
                        phase_next   = PH_SEND;
                        elapsed_next = '0;
                        wait_next    = 24'd0;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_LISTEN:
                begin
                    // foreign traffic: back off asleep
                    if (traffic)
                    begin
                        phase_next   = PH_SLEEP;
                        elapsed_next = '0;
                        wait_next    = item.drawn_wait;
                    end
                end
                PH_WPONG:
                begin
                    if (item.packet_kind == PK_PONG)
                    begin
                        retry_next   = 8'd0;
                        phase_next   = PH_PREP;
                        elapsed_next = '0;
                        wait_next    = 24'd0;
                    end
                end
                PH_WREADY:
                begin
                    if (item.packet_kind == PK_ACK)
                    begin
                        seq_next     = SEQ_BITS'(1);
                        retry_next   = 8'd0;
                        phase_next   = PH_READ;
                        elapsed_next = '0;
                        wait_next    = 24'd0;
                    end
                end
                PH_WACK:
                begin
                    if (item.packet_kind == PK_ACK)
                    begin
                        seq_next     = seq_reg + 1'b1;
                        retry_next   = 8'd0;
                        phase_next   = PH_READ;
                        elapsed_next = '0;
                        wait_next    = 24'd0;
                    end
                end
                default: ;
            endcase
        end

        res.node_state = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            elapsed_reg <= '0;
            wait_reg    <= 24'd0;
            retry_reg   <= 8'd0;
            seq_reg     <= '0;
            held_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            wait_reg    <= wait_next;
            retry_reg   <= retry_next;
            seq_reg     <= seq_next;
            held_reg    <= held_next;
        end
    end

    a_change_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        step && (phase_next != phase_reg) |=> elapsed_reg == '0)
        else $error("elapsed time not cleared on a phase change");

    a_packet_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.opcode == OP_PACKET) && (phase_next == phase_reg) |=> $stable(elapsed_reg))
        else $error("packet request moved elapsed time");

    a_send_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
        step && (res.send_kind != SEND_NONE)
        |=> (phase_reg == PH_WPONG) || (phase_reg == PH_WREADY) || (phase_reg == PH_WACK))
        else $error("transmit did not enter a wait phase");

    a_idle_only_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(seq_reg) && $stable(retry_reg))
        else $error("state moved without a request");

endmodule

// ===== rtl/radio_node_upload_sequencer.sv =====
// channel   | dir | handshake         | payload
// s_axis    | in  | s_tvalid/s_tready | s_tdata (item fields), s_tuser (opcode)
// m_axis    | out | m_tvalid/m_tready | m_tdata (result fields)
// apb cfg   | in  | psel/penable      | paddr, pwdata, prdata; pready tied high
//
// one request is accepted per cycle while the output drains; its result is loaded into the
// result register by the single phase update once the held request moves on
// input and output registers form a two-stage pipeline with full throughput
// a stalled output holds its result and back-pressures the input register
// rst_n clears the phase state, handshake flags and configuration registers
// top level: input register, rnus_core state update, result register, rnus_cfg
module radio_node_upload_sequencer
    import rnus_pkg::*;
#(
    parameter int SEQ_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] packet_kind, [34:3] packet_device, [35] radio_transmitting,
    // [37:36] chunk_status, [45:38] chunk_length, [69:46] drawn_wait, [71:70] zero
    input  logic [71:0] s_tdata,
    // [0] opcode
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] node_state, [5:4] send_kind, [13:6] send_sequence,
    // [21:14] send_length, [23:22] radio_mode, [24] read_request,
    // [26:25] event_res, [31:27] zero
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg;
    in_item_t  in_item;
    in_item_t  in_reg;
    logic      in_valid_reg;
    res_item_t res;
    res_item_t out_reg;
    logic      out_valid_reg;
    logic      step;

    assign in_item.opcode             = s_tuser[0];
    assign in_item.packet_kind        = s_tdata[2:0];
    assign in_item.packet_device      = s_tdata[34:3];
    assign in_item.radio_transmitting = s_tdata[35];
    assign in_item.chunk_status       = s_tdata[37:36];
    assign in_item.chunk_length       = s_tdata[45:38];
    assign in_item.drawn_wait         = s_tdata[69:46];

    // the held request moves on when the result slot is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    rnus_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rnus_core #(
        .SEQ_BITS (SEQ_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (in_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= in_item;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.event_res, out_reg.read_request, out_reg.radio_mode,
                       out_reg.send_length, out_reg.send_sequence, out_reg.send_kind,
                       out_reg.node_state};

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready && in_valid_reg |-> !s_tready)
        else $error("input accepted while both stages are stalled");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost after a state update");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && m_tready && !step |=> !out_valid_reg)
        else $error("result repeated after it was taken");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench for radio_node_upload_sequencer: directed rows, then state-aware random requests
// under several idle and stall patterns; each result is checked against the in-bench
// predictor or a fixed row; depends on rtl/rnus_pkg.sv, rtl/radio_node_upload_sequencer.sv
module testbench;
    import rnus_pkg::*;

    localparam int LIMIT = 600000;

    localparam logic [2:0]  PK_PING  = 3'd0;
    localparam logic [2:0]  PK_OTHER = 3'd5;
    localparam logic [1:0]  CS_NONE  = 2'd0;
    localparam logic [1:0]  CS_BAD   = 2'd3;
    localparam logic [31:0] OWN_ID   = 32'hA5A5_0001;

    typedef struct {
        in_item_t  item;
        bit        fixed;
        res_item_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    radio_node_upload_sequencer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // node model state
    cfg_t            cfg;
    phase_t          cur_phase;
    logic [24:0]     ms_in_phase;
    logic [23:0]     backoff_ms;
    logic [7:0]      retry_cnt;
    logic [7:0]      seq_num;
    logic [7:0]      chunk_len;
    bit              item_acted;
    bit              steady_upload;

    res_item_t       pending_results[$];
    row_t            directed_rows[$];
    int              sender_idle_pct = 0;
    int              stall_pct = 0;
    int              errors = 0;
    int              cycle_cnt = 0;

    function automatic void enter(phase_t nxt, logic [23:0] timer);
        cur_phase = nxt;
        ms_in_phase = '0;
        backoff_ms = timer;
    endfunction

    function automatic res_item_t step_node(in_item_t it);
        res_item_t r;
        logic traffic;
        r = '0;
        item_acted = 1'b0;
        if (it.opcode == OP_TICK) begin
            item_acted = 1'b1;
            if (ms_in_phase != ELAPSED_MAX)
                ms_in_phase = ms_in_phase + 1'b1;
            case (cur_phase)
                PH_START: begin
                    retry_cnt = '0;
                    enter(PH_LISTEN, '0);
                end
                PH_IDLE, PH_SLEEP: begin
                    r.radio_mode = MODE_IDLE;
                    // a zero back-off never expires
                    if (backoff_ms != 0 && ms_in_phase > backoff_ms)
                        enter(PH_LISTEN, '0);
                end
                PH_LISTEN: begin
                    retry_cnt = '0;
                    r.radio_mode = MODE_RX;
                    if (ms_in_phase > cfg.listen_window_ms)
                        enter(PH_PING, '0);
                end
                PH_PING: begin
                    r.send_kind = SEND_PING;
                    r.send_sequence = seq_num;
                    enter(PH_WPONG, '0);
                end
                PH_PREP: begin
                    r.send_kind = SEND_PREP;
                    r.send_sequence = seq_num;
                    enter(PH_WREADY, '0);
                end
                PH_SEND: begin
                    r.send_kind = SEND_DATA;
                    r.send_sequence = seq_num;
                    r.send_length = chunk_len;
                    enter(PH_WACK, '0);
                end
                PH_WPONG, PH_WREADY, PH_WACK: begin
                    if (!it.radio_transmitting) begin
                        r.radio_mode = MODE_RX;
                        if (ms_in_phase > cfg.receive_window_ms) begin
                            if (cur_phase != PH_WPONG && retry_cnt < cfg.max_retries) begin
                                retry_cnt = retry_cnt + 1'b1;
                                r.event_res = EV_RETRY;
                                enter(cur_phase == PH_WREADY ? PH_PREP : PH_SEND, '0);
                            end
                            else begin
                                r.event_res = EV_FAIL;
                                enter(PH_LISTEN, '0);
                            end
                        end
                    end
                end
                PH_READ: begin
                    r.read_request = 1'b1;
                    if (it.chunk_status == CS_END) begin
                        r.event_res = EV_DONE;
                        enter(PH_IDLE, it.drawn_wait);
                    end
                    else if (it.chunk_status == CS_READY && it.chunk_length != 0) begin
                        chunk_len = it.chunk_length > CHUNK_MAX ? CHUNK_MAX : it.chunk_length;
                        enter(PH_SEND, '0);
                    end
                end
                default: ;
            endcase
        end
        else begin
            traffic = it.packet_kind != PK_ACK && it.packet_device != cfg.own_device_id;
            case (cur_phase)
                PH_LISTEN: begin
                    if (traffic) begin
                        item_acted = 1'b1;
                        enter(PH_SLEEP, it.drawn_wait);
                    end
                end
                PH_WPONG: begin
                    if (it.packet_kind == PK_PONG) begin
                        item_acted = 1'b1;
                        retry_cnt = '0;
                        enter(PH_PREP, '0);
                    end
                end
                PH_WREADY: begin
                    if (it.packet_kind == PK_ACK) begin
                        item_acted = 1'b1;
                        seq_num = 8'd1;
                        retry_cnt = '0;
                        enter(PH_READ, '0);
                    end
                end
                PH_WACK: begin
                    if (it.packet_kind == PK_ACK) begin
                        item_acted = 1'b1;
                        seq_num = seq_num + 1'b1;
                        retry_cnt = '0;
                        enter(PH_READ, '0);
                    end
                end
                default: ;
            endcase
        end
        r.node_state = cur_phase;
        return r;
    endfunction

    // mostly requests that move the handshake forward, some noise
    function automatic in_item_t make_item();
        in_item_t it;
        int pick;
        it.opcode = OP_TICK;
        it.packet_kind = 3'($urandom_range(7, 0));
        it.packet_device = $urandom();
        it.radio_transmitting = 1'b0;
        it.chunk_status = 2'($urandom_range(3, 0));
        it.chunk_length = 8'($urandom_range(255, 0));
        it.drawn_wait = 24'($urandom());
        pick = $urandom_range(99, 0);
        if (!steady_upload && $urandom_range(99, 0) < 25) begin
            it.opcode = 1'($urandom_range(1, 0));
            it.radio_transmitting = 1'($urandom_range(1, 0));
        end
        else begin
            case (cur_phase)
                PH_LISTEN: begin
                    if (!steady_upload && pick < 15) begin
                        it.opcode = OP_PACKET;
                        if ($urandom_range(1, 0))
                            it.packet_device = cfg.own_device_id;
                    end
                end
                PH_WPONG, PH_WREADY, PH_WACK: begin
                    if (steady_upload || pick < 30) begin
                        it.opcode = OP_PACKET;
                        if (steady_upload || $urandom_range(3, 0) != 0)
                            it.packet_kind = cur_phase == PH_WPONG ? PK_PONG : PK_ACK;
                    end
                    else
                        it.radio_transmitting = $urandom_range(99, 0) < 20;
                end
                PH_READ: begin
                    if (steady_upload || (pick >= 20 && pick < 70)) begin
                        it.chunk_status = CS_READY;
                        if (steady_upload || $urandom_range(19, 0) != 0)
                            it.chunk_length = 8'($urandom_range(255, 1));
                        else
                            it.chunk_length = '0;
                    end
                    else if (pick < 20)
                        it.chunk_status = CS_NONE;
                    else if (pick < 85)
                        it.chunk_status = CS_END;
                    else
                        it.chunk_status = CS_BAD;
                end
                default: ;
            endcase
        end
        // keep back-off short wherever it can be armed
        if ((it.opcode == OP_PACKET && cur_phase == PH_LISTEN)
                || (it.opcode == OP_TICK && cur_phase == PH_READ && it.chunk_status == CS_END))
            it.drawn_wait = 24'($urandom_range(12, 1));
        return it;
    endfunction

    task automatic add_row(logic op, logic [2:0] kind, logic [31:0] dev, logic tx,
                           logic [1:0] cs, logic [7:0] len, logic [23:0] drawn,
                           bit fixed, res_item_t want);
        row_t r;
        r.item = '{op, kind, dev, tx, cs, len, drawn};
        r.fixed = fixed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    task automatic send_item(in_item_t it, bit fixed, res_item_t want);
        res_item_t predicted;
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it.drawn_wait, it.chunk_length, it.chunk_status,
                    it.radio_transmitting, it.packet_device, it.packet_kind};
        s_tuser <= it.opcode;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = step_node(it);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEVICE:  cfg.own_device_id = val;
            REG_LISTEN:  cfg.listen_window_ms = val[23:0];
            REG_RECEIVE: cfg.receive_window_ms = val[23:0];
            REG_RETRIES: cfg.max_retries = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] dev, logic [23:0] lw, logic [23:0] rw,
                              logic [7:0] retries);
        drain();
        write_reg(REG_DEVICE, dev);
        write_reg(REG_LISTEN, {8'd0, lw});
        write_reg(REG_RECEIVE, {8'd0, rw});
        write_reg(REG_RETRIES, {24'd0, retries});
    endtask

    task automatic run_random(int n_items, int idle_pct, int stall, bit pause_mid);
        int done;
        done = 0;
        sender_idle_pct = idle_pct;
        stall_pct = stall;
        while (done < n_items) begin
            if (pause_mid && done == n_items / 2) begin
                // hold off until every outstanding result is back
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            send_item(make_item(), 1'b0, '0);
            if (item_acted)
                done++;
        end
    endtask

    // result checker and receiver back-pressure
    always @(posedge clk) begin
        res_item_t got;
        res_item_t want;
        m_tready <= $urandom_range(99, 0) >= stall_pct;
        if (m_tvalid && m_tready) begin
            got.node_state = m_tdata[3:0];
            got.send_kind = m_tdata[5:4];
            got.send_sequence = m_tdata[13:6];
            got.send_length = m_tdata[21:14];
            got.radio_mode = m_tdata[23:22];
            got.read_request = m_tdata[24];
            got.event_res = m_tdata[26:25];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("mismatch: state %0d/%0d kind %0d/%0d seq %0d/%0d len %0d/%0d",
                               want.node_state, got.node_state, want.send_kind, got.send_kind,
                               want.send_sequence, got.send_sequence,
                               want.send_length, got.send_length);
                        $display(" mode %0d/%0d rd %0d/%0d ev %0d/%0d (want/got)",
                                 want.radio_mode, got.radio_mode,
                                 want.read_request, got.read_request,
                                 want.event_res, got.event_res);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int n;
        cfg = '{DEVICE_RST, LISTEN_RST, RECEIVE_RST, RETRIES_RST};
        cur_phase = PH_START;
        ms_in_phase = '0;
        backoff_ms = '0;
        retry_cnt = '0;
        seq_num = '0;
        chunk_len = '0;
        steady_upload = 1'b0;

        // walk one upload: ping, prepare with a retry, one chunk with a data retry, give up
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b1,
                res_item_t'{PH_LISTEN, SEND_NONE, 8'd0, 8'd0, MODE_KEEP, 1'b0, EV_NONE});
        add_row(OP_PACKET, PK_ACK, 32'hFFFF_FFFF, 1'b1, CS_BAD, 8'd255, 24'hFF_FFFF, 1'b1,
                res_item_t'{PH_LISTEN, SEND_NONE, 8'd0, 8'd0, MODE_KEEP, 1'b0, EV_NONE});
        add_row(OP_PACKET, PK_PING, OWN_ID, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b1,
                res_item_t'{PH_PING, SEND_NONE, 8'd0, 8'd0, MODE_RX, 1'b0, EV_NONE});
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b1,
                res_item_t'{PH_WPONG, SEND_PING, 8'd0, 8'd0, MODE_KEEP, 1'b0, EV_NONE});
        add_row(OP_TICK, PK_PING, 32'd0, 1'b1, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_PACKET, PK_PONG, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        repeat (4)
            add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_PACKET, PK_ACK, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_READY, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_BAD, 8'd9, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_READY, 8'd255, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b1,
                res_item_t'{PH_WACK, SEND_DATA, 8'd1, 8'd255, MODE_KEEP, 1'b0, EV_NONE});
        repeat (4)
            add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);
        add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b1,
                res_item_t'{PH_LISTEN, SEND_NONE, 8'd0, 8'd0, MODE_RX, 1'b0, EV_FAIL});
        // foreign traffic while listening, then a short sleep
        add_row(OP_PACKET, PK_OTHER, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd2, 1'b1,
                res_item_t'{PH_SLEEP, SEND_NONE, 8'd0, 8'd0, MODE_KEEP, 1'b0, EV_NONE});
        repeat (3)
            add_row(OP_TICK, PK_PING, 32'd0, 1'b0, CS_NONE, 8'd0, 24'd0, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(OWN_ID, 24'd0, 24'd1, 8'd1);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);

        set_config($urandom(), 24'd3, 24'd4, 8'd2);
        run_random(110, 0, 0, 1'b0);
        set_config($urandom(), 24'd0, 24'd0, 8'd0);
        run_random(110, 81, 0, 1'b0);
        set_config(32'd0, 24'd6, 24'd2, 8'd255);
        run_random(110, 0, 81, 1'b0);
        set_config(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'd0);
        run_random(30, 10, 10, 1'b0);
        set_config($urandom(), 24'd1, 24'd1, 8'd3);
        run_random(110, 10, 10, 1'b1);

        // one clean transfer with no noise, several chunks in a row
        set_config($urandom(), 24'd0, 24'd8, 8'd1);
        steady_upload = 1'b1;
        sender_idle_pct = 10;
        stall_pct = 10;
        n = 0;
        while (n < 60) begin
            send_item(make_item(), 1'b0, '0);
            n++;
        end
        steady_upload = 1'b0;

        // end in sleep with a zero back-off, which never expires
        n = 0;
        while (!((cur_phase == PH_SLEEP || cur_phase == PH_IDLE) && backoff_ms == 0)
               && n < 400) begin
            if (cur_phase == PH_LISTEN)
                send_item('{OP_PACKET, PK_OTHER, ~cfg.own_device_id, 1'b0, CS_NONE,
                            8'd0, 24'd0}, 1'b0, '0);
            else
                send_item(make_item(), 1'b0, '0);
            n++;
        end
        repeat (6)
            send_item(make_item(), 1'b0, '0);

        drain();
        repeat (6) @(posedge clk);
        if (pending_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rnus_pkg.sv
rtl/rnus_cfg.sv
rtl/rnus_core.sv
rtl/radio_node_upload_sequencer.sv
bench/testbench.sv
